// ===== rtl/scbd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scbd_pkg
// Shared opcodes, sense codes, response kinds and decode result type of the
// SCSI block command decoder.
// ----------------------------------------------------------------------------
package scbd_pkg;

	// operation codes
	localparam logic [7:0] OP_TEST_UNIT_READY  = 8'h00;
	localparam logic [7:0] OP_REQUEST_SENSE    = 8'h03;
	localparam logic [7:0] OP_READ_6           = 8'h08;
	localparam logic [7:0] OP_WRITE_6          = 8'h0A;
	localparam logic [7:0] OP_INQUIRY          = 8'h12;
	localparam logic [7:0] OP_MODE_SENSE_6     = 8'h1A;
	localparam logic [7:0] OP_START_STOP_UNIT  = 8'h1B;
	localparam logic [7:0] OP_SEND_DIAGNOSTIC  = 8'h1D;
	localparam logic [7:0] OP_PREVENT_ALLOW    = 8'h1E;
	localparam logic [7:0] OP_READ_FORMAT_CAPS = 8'h23;
	localparam logic [7:0] OP_READ_CAPACITY_10 = 8'h25;
	localparam logic [7:0] OP_READ_10          = 8'h28;
	localparam logic [7:0] OP_WRITE_10         = 8'h2A;
	localparam logic [7:0] OP_VERIFY_10        = 8'h2F;
	localparam logic [7:0] OP_MODE_SENSE_10    = 8'h5A;

	localparam int unsigned EVPD_BIT         = 0;
	localparam logic [7:0]  PAGE_UNIT_SERIAL = 8'h80;

	// sense keys and additional sense codes
	localparam logic [3:0] KEY_GOOD       = 4'd0;
	localparam logic [3:0] KEY_ILLEGAL    = 4'd5;
	localparam logic [7:0] ASC_NONE       = 8'h00;
	localparam logic [7:0] ASC_BAD_OPCODE = 8'h20;
	localparam logic [7:0] ASC_LBA_RANGE  = 8'h21;
	localparam logic [7:0] ASC_BAD_FIELD  = 8'h24;
	localparam logic [7:0] ASCQ_NONE      = 8'h00;

	// canned response sizes in bytes
	localparam logic [5:0] SIZE_INQUIRY  = 6'd36;
	localparam logic [5:0] SIZE_SERIAL   = 6'd9;
	localparam logic [5:0] SIZE_SENSE    = 6'd18;
	localparam logic [5:0] SIZE_CAPACITY = 6'd8;
	localparam logic [5:0] SIZE_MODE     = 6'd4;
	localparam logic [5:0] SIZE_FORMAT   = 6'd12;

	typedef enum logic [3:0] {
		KIND_NONE     = 4'd0,
		KIND_INQUIRY  = 4'd1,
		KIND_SERIAL   = 4'd2,
		KIND_SENSE    = 4'd3,
		KIND_CAPACITY = 4'd4,
		KIND_MODE     = 4'd5,
		KIND_FORMAT   = 4'd6,
		KIND_READ     = 4'd7,
		KIND_WRITE    = 4'd8
	} kind_t;

	// decoded command, one per request
	typedef struct packed {
		logic [3:0]  sense_key;
		logic [7:0]  sense_code;
		kind_t       kind;
		logic [5:0]  nbytes;
		logic        block_xfer;
		logic [31:0] start_block;
		logic [15:0] block_count;
	} dec_t;

endpackage
`default_nettype wire

// ===== rtl/scbd_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scbd_decode
// Combinational decode of one command descriptor block into sense key and code,
// response kind, clipped response length and block range.
// ----------------------------------------------------------------------------
module scbd_decode (
	input  wire logic [7:0]  opcode,
	input  wire logic [7:0]  cdb_flags,
	input  wire logic [7:0]  cdb_byte_two,
	input  wire logic [7:0]  cdb_byte_three,
	input  wire logic [7:0]  cdb_byte_four,
	input  wire logic [7:0]  cdb_byte_five,
	input  wire logic [7:0]  cdb_byte_seven,
	input  wire logic [7:0]  cdb_byte_eight,
	input  wire logic [31:0] total_blocks,
	output scbd_pkg::dec_t   dec
);

	logic [31:0] lba;
	logic [15:0] len78;
	logic [15:0] len34;
	logic [32:0] lba_end;
	logic        out_of_range;

	function automatic logic [5:0] clip_len(input logic [15:0] alloc, input logic [5:0] size);
		clip_len = (alloc < {10'd0, size}) ? alloc[5:0] : size;
	endfunction

	assign lba     = {cdb_byte_two, cdb_byte_three, cdb_byte_four, cdb_byte_five};
	assign len78   = {cdb_byte_seven, cdb_byte_eight};
	assign len34   = {cdb_byte_three, cdb_byte_four};
	assign lba_end = {1'b0, lba} + {17'd0, len78};
	// range check at 33 bits so a start near the top cannot wrap
	assign out_of_range = (lba >= total_blocks) || (lba_end > {1'b0, total_blocks});

	always_comb begin
		dec             = '0;
		dec.sense_key   = scbd_pkg::KEY_GOOD;
		dec.sense_code  = scbd_pkg::ASC_NONE;
		dec.kind        = scbd_pkg::KIND_NONE;
		case (opcode)
			scbd_pkg::OP_INQUIRY: begin
				if (cdb_flags[scbd_pkg::EVPD_BIT]) begin
					if (cdb_byte_two == scbd_pkg::PAGE_UNIT_SERIAL) begin
						dec.kind   = scbd_pkg::KIND_SERIAL;
						dec.nbytes = clip_len(len34, scbd_pkg::SIZE_SERIAL);
					end else begin
						dec.sense_key  = scbd_pkg::KEY_ILLEGAL;
						dec.sense_code = scbd_pkg::ASC_BAD_FIELD;
					end
				end else begin
					dec.kind   = scbd_pkg::KIND_INQUIRY;
					dec.nbytes = clip_len(len34, scbd_pkg::SIZE_INQUIRY);
				end
			end
			scbd_pkg::OP_REQUEST_SENSE: begin
				dec.kind   = scbd_pkg::KIND_SENSE;
				dec.nbytes = clip_len({8'd0, cdb_byte_four}, scbd_pkg::SIZE_SENSE);
			end
			scbd_pkg::OP_TEST_UNIT_READY, scbd_pkg::OP_START_STOP_UNIT: begin
				dec.kind = scbd_pkg::KIND_NONE;
			end
			scbd_pkg::OP_READ_CAPACITY_10: begin
				dec.kind   = scbd_pkg::KIND_CAPACITY;
				dec.nbytes = scbd_pkg::SIZE_CAPACITY;
			end
			scbd_pkg::OP_SEND_DIAGNOSTIC: begin
				dec.sense_key  = scbd_pkg::KEY_ILLEGAL;
				dec.sense_code = scbd_pkg::ASC_BAD_FIELD;
			end
			scbd_pkg::OP_READ_10, scbd_pkg::OP_WRITE_10: begin
				if (out_of_range) begin
					dec.sense_key  = scbd_pkg::KEY_ILLEGAL;
					dec.sense_code = scbd_pkg::ASC_LBA_RANGE;
				end else begin
					dec.kind        = (opcode == scbd_pkg::OP_READ_10) ?
						scbd_pkg::KIND_READ : scbd_pkg::KIND_WRITE;
					dec.block_xfer  = 1'b1;
					dec.start_block = lba;
					dec.block_count = len78;
				end
			end
			scbd_pkg::OP_MODE_SENSE_6: begin
				dec.kind   = scbd_pkg::KIND_MODE;
				dec.nbytes = clip_len({8'd0, cdb_byte_four}, scbd_pkg::SIZE_MODE);
			end
			scbd_pkg::OP_MODE_SENSE_10: begin
				dec.kind   = scbd_pkg::KIND_MODE;
				dec.nbytes = clip_len(len78, scbd_pkg::SIZE_MODE);
			end
			scbd_pkg::OP_READ_FORMAT_CAPS: begin
				dec.kind   = scbd_pkg::KIND_FORMAT;
				dec.nbytes = clip_len(len78, scbd_pkg::SIZE_FORMAT);
			end
			// recognised but unimplemented commands share the unknown opcode answer
			scbd_pkg::OP_PREVENT_ALLOW, scbd_pkg::OP_READ_6, scbd_pkg::OP_WRITE_6,
			scbd_pkg::OP_VERIFY_10: begin
				dec.sense_key  = scbd_pkg::KEY_ILLEGAL;
				dec.sense_code = scbd_pkg::ASC_BAD_OPCODE;
			end
			default: begin
				dec.sense_key  = scbd_pkg::KEY_ILLEGAL;
				dec.sense_code = scbd_pkg::ASC_BAD_OPCODE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/scsi_block_command_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scsi_block_command_decoder
// Decodes SCSI command descriptor blocks into status, sense and transfer info.
// ----------------------------------------------------------------------------
// One command request is accepted per clock while s_axis_tready is high, and
// its answer reaches the result side through an input register, a decode
// stage that also forms the block transfer byte count with one 16 x 16
// multiply, and an output register that takes the saturating residue subtract.
// Each stage holds its request while the next is full, so a stall on the
// result side fills the pipeline before the input stops. The user is to write
// total_blocks (index 0) and the block size in bytes (index 1) through the cfg
// port only while no request is in flight; the block does not enforce this.
// Every command overwrites the kept sense triple, REQUEST SENSE included, so
// REQUEST SENSE always reports good status and the triple needs no storage.
module scsi_block_command_decoder (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// configuration write port
	input  wire logic         cfg_we,
	input  wire logic         cfg_addr,
	input  wire logic [31:0]  cfg_wdata,
	// command requests
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// opcode, cdb_flags, cdb_byte_two, cdb_byte_three, cdb_byte_four,
	// cdb_byte_five, cdb_byte_seven, cdb_byte_eight, host_transfer_length
	input  wire logic [95:0]  s_axis_tdata,
	// results
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// status_good, sense_key, sense_code, sense_qualifier, response_kind,
	// response_bytes, start_block, block_count, residue_bytes, one zero pad bit
	output logic [111:0]      m_axis_tdata
);

	localparam logic [0:0] REG_TOTAL_BLOCKS = 1'b0;
	localparam logic [0:0] REG_BLOCK_SIZE   = 1'b1;

	logic [31:0] total_blocks_q;
	logic [15:0] block_size_q;

	logic        valid_s1;
	logic [95:0] cdb_s1;
	logic        valid_s2;
	scbd_pkg::dec_t dec_s2;
	logic [31:0] moved_s2;
	logic [31:0] host_s2;

	logic        out_valid_q;
	logic [110:0] out_q;

	logic        adv_out;
	logic        adv_s2;
	logic        adv_s1;

	scbd_pkg::dec_t dec;
	logic [31:0] product;
	logic [31:0] residue;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_blocks_q <= 32'd256;
			block_size_q   <= 16'd512;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_TOTAL_BLOCKS: total_blocks_q <= cfg_wdata;
				REG_BLOCK_SIZE:   block_size_q   <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// each stage may load when it is empty or its contents move on
	assign adv_out       = !out_valid_q || m_axis_tready;
	assign adv_s2        = !valid_s2 || adv_out;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	scbd_decode u_decode (
		.opcode         (cdb_s1[7:0]),
		.cdb_flags      (cdb_s1[15:8]),
		.cdb_byte_two   (cdb_s1[23:16]),
		.cdb_byte_three (cdb_s1[31:24]),
		.cdb_byte_four  (cdb_s1[39:32]),
		.cdb_byte_five  (cdb_s1[47:40]),
		.cdb_byte_seven (cdb_s1[55:48]),
		.cdb_byte_eight (cdb_s1[63:56]),
		.total_blocks   (total_blocks_q),
		.dec            (dec)
	);

	// a 16 x 16 product always fits 32 bits
	assign product = {16'd0, dec.block_count} * {16'd0, block_size_q};

	assign residue = (host_s2 > moved_s2) ? (host_s2 - moved_s2) : 32'd0;

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			cdb_s1 <= s_axis_tdata;
		end
		if (adv_s2 && valid_s1) begin
			dec_s2   <= dec;
			host_s2  <= cdb_s1[95:64];
			moved_s2 <= dec.block_xfer ? product : {26'd0, dec.nbytes};
		end
		if (adv_out && valid_s2) begin
			out_q <= {residue,
				dec_s2.block_count,
				dec_s2.start_block,
				dec_s2.nbytes,
				dec_s2.kind,
				scbd_pkg::ASCQ_NONE,
				dec_s2.sense_code,
				dec_s2.sense_key,
				(dec_s2.sense_key == scbd_pkg::KEY_GOOD)};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q};

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SCSI block command decoder: a directed table of
// command requests, then randomised requests over several medium geometries,
// each result checked field by field against a table row or the predictor.
// ----------------------------------------------------------------------------
module testbench;
	import scbd_pkg::*;

	localparam logic REG_TOTAL_BLOCKS    = 1'b0;
	localparam logic REG_BLOCK_SIZE      = 1'b1;
	localparam int   ITEMS_PER_PHASE     = 135;
	localparam int   NUM_PHASES          = 7;
	localparam int   RECEIVER_HOLD       = 120;

	// command request, opcode in the lowest bits
	typedef struct packed {
		logic [31:0] host;
		logic [7:0]  b8;
		logic [7:0]  b7;
		logic [7:0]  b5;
		logic [7:0]  b4;
		logic [7:0]  b3;
		logic [7:0]  b2;
		logic [7:0]  flags;
		logic [7:0]  op;
	} cmd_t;

	// decoded answer, status_good in the lowest bit
	typedef struct packed {
		logic        pad;
		logic [31:0] residue_bytes;
		logic [15:0] block_count;
		logic [31:0] start_block;
		logic [5:0]  response_bytes;
		kind_t       response_kind;
		logic [7:0]  sense_qualifier;
		logic [7:0]  sense_code;
		logic [3:0]  sense_key;
		logic        status_good;
	} result_t;

	typedef struct {
		cmd_t    cmd;
		bit      typed;
		result_t res;
	} row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic         cfg_addr = 1'b0;
	logic [31:0]  cfg_wdata = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// opcode, cdb_flags, cdb_byte_two .. cdb_byte_five, cdb_byte_seven,
	// cdb_byte_eight, host_transfer_length
	logic [95:0]  s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// status_good, sense_key, sense_code, sense_qualifier, response_kind,
	// response_bytes, start_block, block_count, residue_bytes, pad bit
	logic [111:0] m_axis_tdata;

	// predictor copy of the registers and the kept sense triple
	logic [31:0] model_total_blocks;
	logic [15:0] model_block_bytes;
	logic [3:0]  kept_key;
	logic [7:0]  kept_code;
	logic [7:0]  kept_qualifier;

	result_t pending_results[$];
	row_t    directed[$];
	int      mismatch_count = 0;
	bit      sender_gaps = 1'b1;
	bit      receiver_stalls = 1'b1;
	bit      hold_request = 1'b0;
	result_t got_res;
	result_t want_res;

	scsi_block_command_decoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #2 clk = ~clk;

	function automatic logic [5:0] clip_alloc(logic [15:0] alloc, logic [5:0] size);
		return (alloc < {10'b0, size}) ? alloc[5:0] : size;
	endfunction

	function automatic result_t decode_command(cmd_t c);
		result_t     r;
		logic [31:0] lba;
		logic [15:0] len78;
		logic [63:0] moved;
		r = '0;
		r.response_kind = KIND_NONE;
		r.sense_key = KEY_GOOD;
		r.sense_code = ASC_NONE;
		r.sense_qualifier = ASCQ_NONE;
		lba = {c.b2, c.b3, c.b4, c.b5};
		len78 = {c.b7, c.b8};
		moved = '0;
		case (c.op)
			OP_INQUIRY: begin
				if (c.flags[EVPD_BIT]) begin
					if (c.b2 == PAGE_UNIT_SERIAL) begin
						r.response_kind = KIND_SERIAL;
						r.response_bytes = clip_alloc({c.b3, c.b4}, SIZE_SERIAL);
					end else begin
						r.sense_key = KEY_ILLEGAL;
						r.sense_code = ASC_BAD_FIELD;
					end
				end else begin
					r.response_kind = KIND_INQUIRY;
					r.response_bytes = clip_alloc({c.b3, c.b4}, SIZE_INQUIRY);
				end
			end
			OP_REQUEST_SENSE: begin
				r.response_kind = KIND_SENSE;
				r.response_bytes = clip_alloc({8'b0, c.b4}, SIZE_SENSE);
			end
			OP_TEST_UNIT_READY, OP_START_STOP_UNIT: begin
			end
			OP_READ_CAPACITY_10: begin
				r.response_kind = KIND_CAPACITY;
				r.response_bytes = SIZE_CAPACITY;
			end
			OP_SEND_DIAGNOSTIC: begin
				r.sense_key = KEY_ILLEGAL;
				r.sense_code = ASC_BAD_FIELD;
			end
			OP_READ_10, OP_WRITE_10: begin
				// range test done at 33 bits so the end of the run cannot wrap
				if (lba >= model_total_blocks ||
						{1'b0, lba} + {17'b0, len78} > {1'b0, model_total_blocks}) begin
					r.sense_key = KEY_ILLEGAL;
					r.sense_code = ASC_LBA_RANGE;
				end else begin
					r.response_kind = (c.op == OP_READ_10) ? KIND_READ : KIND_WRITE;
					r.start_block = lba;
					r.block_count = len78;
					moved = {48'b0, len78} * {48'b0, model_block_bytes};
				end
			end
			OP_MODE_SENSE_6: begin
				r.response_kind = KIND_MODE;
				r.response_bytes = clip_alloc({8'b0, c.b4}, SIZE_MODE);
			end
			OP_MODE_SENSE_10: begin
				r.response_kind = KIND_MODE;
				r.response_bytes = clip_alloc(len78, SIZE_MODE);
			end
			OP_READ_FORMAT_CAPS: begin
				r.response_kind = KIND_FORMAT;
				r.response_bytes = clip_alloc(len78, SIZE_FORMAT);
			end
			default: begin
				r.sense_key = KEY_ILLEGAL;
				r.sense_code = ASC_BAD_OPCODE;
			end
		endcase
		moved = moved + {58'b0, r.response_bytes};
		r.residue_bytes = ({32'b0, c.host} > moved) ? c.host - moved[31:0] : '0;
		r.status_good = (r.sense_key == KEY_GOOD);
		// every command overwrites the kept triple, request sense included
		kept_key = r.sense_key;
		kept_code = r.sense_code;
		kept_qualifier = ASCQ_NONE;
		return r;
	endfunction

	function automatic cmd_t mk_cmd(logic [7:0] op, logic [7:0] flags, logic [7:0] b2,
			logic [7:0] b3, logic [7:0] b4, logic [7:0] b5, logic [7:0] b7,
			logic [7:0] b8, logic [31:0] host);
		cmd_t c;
		c.op = op;
		c.flags = flags;
		c.b2 = b2;
		c.b3 = b3;
		c.b4 = b4;
		c.b5 = b5;
		c.b7 = b7;
		c.b8 = b8;
		c.host = host;
		return c;
	endfunction

	function automatic result_t mk_res(logic [3:0] key, logic [7:0] code, kind_t kind,
			logic [5:0] nbytes, logic [31:0] start, logic [15:0] count, logic [31:0] residue);
		result_t r;
		r = '0;
		r.status_good = (key == KEY_GOOD);
		r.sense_key = key;
		r.sense_code = code;
		r.sense_qualifier = ASCQ_NONE;
		r.response_kind = kind;
		r.response_bytes = nbytes;
		r.start_block = start;
		r.block_count = count;
		r.residue_bytes = residue;
		return r;
	endfunction

	function automatic cmd_t random_command();
		cmd_t            c;
		int              pick;
		logic [7:0]      plain_ops[8];
		logic [7:0]      refused_ops[4];
		longint unsigned room;
		longint unsigned moved;
		logic [31:0]     lba;
		logic [15:0]     count;
		plain_ops = '{OP_TEST_UNIT_READY, OP_REQUEST_SENSE, OP_MODE_SENSE_6,
			OP_START_STOP_UNIT, OP_SEND_DIAGNOSTIC, OP_READ_FORMAT_CAPS,
			OP_READ_CAPACITY_10, OP_MODE_SENSE_10};
		refused_ops = '{OP_READ_6, OP_WRITE_6, OP_PREVENT_ALLOW, OP_VERIFY_10};
		c = cmd_t'({$urandom(), $urandom(), $urandom()});
		pick = $urandom_range(0, 99);
		moved = 0;
		if (pick < 35) begin
			c.op = $urandom_range(0, 1) ? OP_READ_10 : OP_WRITE_10;
			lba = {c.b2, c.b3, c.b4, c.b5};
			count = {c.b7, c.b8};
			case ($urandom_range(0, 3))
				0: begin
					lba = $urandom_range(0, model_total_blocks - 1);
					room = longint'(model_total_blocks) - longint'(lba);
					count = $urandom_range(0, (room > 64) ? 64 : room);
				end
				1: begin
					// near the end of the medium, either side of the limit
					lba = model_total_blocks -
						$urandom_range(1, (model_total_blocks < 4) ? model_total_blocks : 4);
					count = $urandom_range(0, 5);
				end
				2: lba = $urandom_range(0, model_total_blocks);
				default: begin
				end
			endcase
			{c.b2, c.b3, c.b4, c.b5} = lba;
			{c.b7, c.b8} = count;
			moved = longint'(count) * longint'(model_block_bytes);
		end else if (pick < 50) begin
			c.op = OP_INQUIRY;
			if ($urandom_range(0, 2) != 0)
				c.b2 = PAGE_UNIT_SERIAL;
			if ($urandom_range(0, 1)) begin
				c.b3 = 8'h00;
				c.b4 = $urandom_range(0, 40);
			end
		end else if (pick < 80) begin
			c.op = plain_ops[$urandom_range(0, 7)];
			if ($urandom_range(0, 1)) begin
				c.b4 = $urandom_range(0, 20);
				c.b7 = 8'h00;
				c.b8 = $urandom_range(0, 14);
			end
		end else if (pick < 90) begin
			c.op = refused_ops[$urandom_range(0, 3)];
		end
		case ($urandom_range(0, 4))
			0: c.host = $urandom_range(0, 600);
			1: c.host = 32'hFFFF_FFFF;
			2: c.host = 32'h0;
			3: c.host = moved - 1 + $urandom_range(0, 2);
			default: begin
			end
		endcase
		return c;
	endfunction

	task automatic offer_command(input cmd_t c, input bit typed, input result_t typed_res);
		result_t predicted;
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		do @(posedge clk); while (!s_axis_tready);
		predicted = decode_command(c);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	task automatic set_geometry(input logic [31:0] total, input logic [15:0] bpb);
		while (pending_results.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= REG_TOTAL_BLOCKS;
		cfg_wdata <= total;
		@(posedge clk);
		cfg_addr <= REG_BLOCK_SIZE;
		cfg_wdata <= {16'b0, bpb};
		@(posedge clk);
		cfg_we <= 1'b0;
		model_total_blocks = total;
		model_block_bytes = bpb;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// result side: random stalls, plus one long hold to back the pipeline up
	initial begin
		forever begin
			if (hold_request) begin
				m_axis_tready <= 1'b0;
				repeat (RECEIVER_HOLD) @(posedge clk);
				hold_request = 1'b0;
			end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_res = result_t'(m_axis_tdata);
			if (pending_results.size() == 0) begin
				$display("%0t: result with no request waiting, expected none actual %h",
					$time, m_axis_tdata);
				mismatch_count++;
			end else begin
				want_res = pending_results.pop_front();
				check_field("status_good", want_res.status_good, got_res.status_good);
				check_field("sense_key", want_res.sense_key, got_res.sense_key);
				check_field("sense_code", want_res.sense_code, got_res.sense_code);
				check_field("sense_qualifier", want_res.sense_qualifier,
					got_res.sense_qualifier);
				check_field("response_kind", want_res.response_kind, got_res.response_kind);
				check_field("response_bytes", want_res.response_bytes,
					got_res.response_bytes);
				check_field("start_block", want_res.start_block, got_res.start_block);
				check_field("block_count", want_res.block_count, got_res.block_count);
				check_field("residue_bytes", want_res.residue_bytes, got_res.residue_bytes);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		logic [31:0] total;
		logic [15:0] bpb;
		int          drain;
		model_total_blocks = 32'd256;
		model_block_bytes = 16'd512;
		kept_key = KEY_GOOD;
		kept_code = ASC_NONE;
		kept_qualifier = ASCQ_NONE;

		// directed table, reset geometry of 256 blocks of 512 bytes
		directed.push_back('{mk_cmd(OP_TEST_UNIT_READY, 0, 0, 0, 0, 0, 0, 0, 32'h0), 1,
			mk_res(KEY_GOOD, ASC_NONE, KIND_NONE, 0, 0, 0, 32'h0)});
		directed.push_back('{mk_cmd(OP_TEST_UNIT_READY, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'hFF, 8'hFF, 32'hFFFF_FFFF), 1,
			mk_res(KEY_GOOD, ASC_NONE, KIND_NONE, 0, 0, 0, 32'hFFFF_FFFF)});
		directed.push_back('{mk_cmd(OP_START_STOP_UNIT, 0, 0, 0, 1, 0, 0, 0, 32'd100), 1,
			mk_res(KEY_GOOD, ASC_NONE, KIND_NONE, 0, 0, 0, 32'd100)});
		directed.push_back('{mk_cmd(8'hFF, 0, 0, 0, 0, 0, 0, 0, 32'd7), 1,
			mk_res(KEY_ILLEGAL, ASC_BAD_OPCODE, KIND_NONE, 0, 0, 0, 32'd7)});
		directed.push_back('{mk_cmd(OP_READ_6, 0, 0, 0, 1, 0, 0, 0, 32'h1000), 1,
			mk_res(KEY_ILLEGAL, ASC_BAD_OPCODE, KIND_NONE, 0, 0, 0, 32'h1000)});
		directed.push_back('{mk_cmd(OP_WRITE_6, 0, 0, 0, 1, 0, 0, 0, 32'h200), 1,
			mk_res(KEY_ILLEGAL, ASC_BAD_OPCODE, KIND_NONE, 0, 0, 0, 32'h200)});
		directed.push_back('{mk_cmd(OP_PREVENT_ALLOW, 0, 0, 0, 1, 0, 0, 0, 32'd0), 1,
			mk_res(KEY_ILLEGAL, ASC_BAD_OPCODE, KIND_NONE, 0, 0, 0, 32'd0)});
		directed.push_back('{mk_cmd(OP_VERIFY_10, 0, 0, 0, 0, 0, 0, 1, 32'd512), 1,
			mk_res(KEY_ILLEGAL, ASC_BAD_OPCODE, KIND_NONE, 0, 0, 0, 32'd512)});
		directed.push_back('{mk_cmd(OP_SEND_DIAGNOSTIC, 8'h04, 0, 0, 0, 0, 0, 0, 32'd5), 1,
			mk_res(KEY_ILLEGAL, ASC_BAD_FIELD, KIND_NONE, 0, 0, 0, 32'd5)});
		// request sense right after an error still reports good
		directed.push_back('{mk_cmd(OP_REQUEST_SENSE, 0, 0, 0, 8'hFF, 0, 0, 0, 32'd18), 1,
			mk_res(KEY_GOOD, ASC_NONE, KIND_SENSE, 6'd18, 0, 0, 32'd0)});
		directed.push_back('{mk_cmd(OP_REQUEST_SENSE, 0, 0, 0, 0, 0, 0, 0, 32'd3), 0, '0});
		directed.push_back('{mk_cmd(OP_INQUIRY, 0, 0, 8'hFF, 8'hFF, 0, 0, 0, 32'd36), 1,
			mk_res(KEY_GOOD, ASC_NONE, KIND_INQUIRY, 6'd36, 0, 0, 32'd0)});
		directed.push_back('{mk_cmd(OP_INQUIRY, 0, 0, 0, 8'd5, 0, 0, 0, 32'd100), 0, '0});
		directed.push_back('{mk_cmd(OP_INQUIRY, 8'h01, PAGE_UNIT_SERIAL, 0, 8'hFF, 0, 0, 0,
			32'd9), 1, mk_res(KEY_GOOD, ASC_NONE, KIND_SERIAL, 6'd9, 0, 0, 32'd0)});
		directed.push_back('{mk_cmd(OP_INQUIRY, 8'hFF, 8'h00, 0, 8'hFF, 0, 0, 0, 32'd40), 1,
			mk_res(KEY_ILLEGAL, ASC_BAD_FIELD, KIND_NONE, 0, 0, 0, 32'd40)});
		directed.push_back('{mk_cmd(OP_READ_CAPACITY_10, 0, 0, 0, 0, 0, 0, 0, 32'd4), 1,
			mk_res(KEY_GOOD, ASC_NONE, KIND_CAPACITY, 6'd8, 0, 0, 32'd0)});
		directed.push_back('{mk_cmd(OP_MODE_SENSE_6, 0, 0, 0, 8'd2, 0, 0, 0, 32'd10), 0, '0});
		directed.push_back('{mk_cmd(OP_MODE_SENSE_10, 0, 0, 0, 0, 0, 8'hFF, 8'hFF, 32'd0), 0,
			'0});
		directed.push_back('{mk_cmd(OP_READ_FORMAT_CAPS, 0, 0, 0, 0, 0, 0, 8'd7, 32'd100), 0,
			'0});
		directed.push_back('{mk_cmd(OP_READ_10, 0, 0, 0, 0, 0, 8'h01, 8'h00, 32'hFFFF_FFFF),
			0, '0});
		directed.push_back('{mk_cmd(OP_WRITE_10, 0, 0, 0, 0, 8'hFF, 0, 8'h01, 32'd100), 0,
			'0});
		// start one past the last block, and a start plus count that would wrap
		directed.push_back('{mk_cmd(OP_READ_10, 0, 0, 0, 8'h01, 0, 0, 0, 32'd9), 1,
			mk_res(KEY_ILLEGAL, ASC_LBA_RANGE, KIND_NONE, 0, 0, 0, 32'd9)});
		directed.push_back('{mk_cmd(OP_WRITE_10, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			32'd1), 1, mk_res(KEY_ILLEGAL, ASC_LBA_RANGE, KIND_NONE, 0, 0, 0, 32'd1)});
		directed.push_back('{mk_cmd(OP_READ_10, 0, 0, 0, 0, 8'd200, 0, 8'd57, 32'd64), 1,
			mk_res(KEY_ILLEGAL, ASC_LBA_RANGE, KIND_NONE, 0, 0, 0, 32'd64)});
		directed.push_back('{mk_cmd(OP_READ_10, 0, 0, 0, 0, 8'd10, 0, 0, 32'd77), 0, '0});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			offer_command(directed[i].cmd, directed[i].typed, directed[i].res);
		s_axis_tvalid <= 1'b0;

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin total = 32'd1; bpb = 16'd1; end
				1: begin total = 32'hFFFF_FFFF; bpb = 16'hFFFF; end
				2: begin total = $urandom_range(1, 64); bpb = $urandom_range(1, 65535); end
				3: begin
					total = $urandom_range(1, 32'hFFFF_FFFF);
					bpb = $urandom_range(1, 65535);
				end
				4: begin total = 32'd16; bpb = 16'hFFFF; end
				5: begin total = 32'hFFFF_FFFF; bpb = 16'd1; end
				default: begin total = 32'd256; bpb = 16'd512; end
			endcase
			// the sender waits here for every outstanding result
			set_geometry(total, bpb);
			if (p == 1)
				hold_request = 1'b1;
			if (p == NUM_PHASES - 1) begin
				sender_gaps = 1'b0;
				receiver_stalls = 1'b0;
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				offer_command(random_command(), 1'b0, '0);
			s_axis_tvalid <= 1'b0;
		end

		drain = 0;
		while (pending_results.size() != 0 && drain < 10000) begin
			@(posedge clk);
			drain++;
		end
		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived, expected %0d actual 0", $time,
				pending_results.size(), pending_results.size());
			mismatch_count++;
		end
		// keep clocking to catch any stray result
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/scbd_pkg.sv
rtl/scbd_decode.sv
rtl/scsi_block_command_decoder.sv
dv/testbench.sv
